// ===== src/char_lcd_shadow_write_engine_assert.svh =====
// Assertion macros shared by the character LCD write engine modules.
`ifndef CHAR_LCD_SHADOW_WRITE_ENGINE_ASSERT_SVH
`define CHAR_LCD_SHADOW_WRITE_ENGINE_ASSERT_SVH

// Check that expr holds in the same cycle as cond.
`define CHLCD_CHECK(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Check that expr holds in the cycle after cond.
`define CHLCD_CHECK_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== src/chlcd_pkg.sv =====
// Shared types, constants and helper functions for the character LCD write engine.
package chlcd_pkg;

   // Display geometry
   localparam int ROWS    = 2;
   localparam int COLUMNS = 16;
   localparam int CELLS   = ROWS * COLUMNS;
   localparam int CELL_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W   = $clog2(COLUMNS + 1);

   // Queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Nibble sequencer: six expander bytes per LCD byte
   localparam logic [2:0] STEP_LAST = 3'd5;

   // Mode codes
   localparam logic [3:0] MODE_RAW_INSTR = 4'd0;
   localparam logic [3:0] MODE_RAW_DATA  = 4'd1;
   localparam logic [3:0] MODE_PUT_CHAR  = 4'd2;
   localparam logic [3:0] MODE_STR_CHAR  = 4'd3;
   localparam logic [3:0] MODE_POSITION  = 4'd4;
   localparam logic [3:0] MODE_CLEAR     = 4'd5;
   localparam logic [3:0] MODE_HOME      = 4'd6;
   localparam logic [3:0] MODE_DISPLAY   = 4'd7;
   localparam logic [3:0] MODE_BACKLIGHT = 4'd8;

   // LCD instruction codes and expander pins
   localparam logic [7:0] CMD_CLEAR    = 8'h01;
   localparam logic [7:0] CMD_HOME     = 8'h02;
   localparam logic [7:0] CMD_DISPLAY  = 8'h08;
   localparam logic [7:0] CMD_POSITION = 8'h80;
   localparam logic [7:0] PIN_BL       = 8'h08;
   localparam logic [7:0] SPACE_CHAR   = 8'h20;

   typedef struct packed {
      logic [3:0] mode;
      logic [7:0] value;
      logic [1:0] row;
      logic [5:0] column;
      logic       last;
      logic       display_on;
      logic       show_cursor;
      logic       show_blink;
      logic       backlight_request;
   } req_word_type;

   typedef struct packed {
      logic [7:0] expander_byte;
      logic       last_byte;
   } rsp_word_type;

   // One queued operation: an LCD byte to split into nibbles, or a single raw byte
   typedef struct packed {
      logic       single;
      logic [7:0] data;
      logic       rs;
      logic       bl;
      logic       last;
   } lcd_op_type;

   // Front to queue: up to two operations per item
   typedef struct packed {
      logic [1:0] count;
      lcd_op_type op0;
      lcd_op_type op1;
   } push_type;

   // Queue head seen by the back
   typedef struct packed {
      logic       valid;
      lcd_op_type op;
   } head_type;

   function automatic lcd_op_type make_op(input logic [7:0] data, input logic rs,
                                          input logic bl, input logic single);
      lcd_op_type op;
      op.single = single;
      op.data   = data;
      op.rs     = rs;
      op.bl     = bl;
      op.last   = 1'b0;
      return op;
   endfunction

   // Set-position instruction for a cursor
   function automatic logic [7:0] pos_byte(input logic [ROW_W-1:0] r,
                                           input logic [COL_W-1:0] c);
      logic [6:0] off;
      case (2'(r))
         2'd0:    off = 7'h00;
         2'd1:    off = 7'h40;
         2'd2:    off = 7'(COLUMNS);
         default: off = 7'(64 + COLUMNS);
      endcase
      return CMD_POSITION | {1'b0, 7'(off + 7'(c))};
   endfunction

endpackage

// ===== src/chlcd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module chlcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/chlcd_front.sv =====
// Front end: accepts words, tracks cursor and shadow screen, emits LCD operations.
`include "char_lcd_shadow_write_engine_assert.svh"

module chlcd_front
   import chlcd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_word_type      req_word,
   input  logic [QCNT_W-1:0] q_free,
   output push_type          push
);

   typedef struct packed {
      logic              is_str;
      logic              is_put;
      logic              in_range;
      logic              do_clear;
      logic              clr_skip;
      logic              simple;
      lcd_op_type        simple_op;
      logic [7:0]        value;
      logic              last;
      logic [CELL_W-1:0] idx;
      logic [7:0]        pos_now;
      logic [7:0]        pos_next;
      logic              bl;
   } stage_b_type;

   // Architectural state
   logic [ROW_W-1:0] cur_row_ff, cur_row_in;
   logic [COL_W-1:0] cur_col_ff, cur_col_in;
   logic             bl_ff, bl_in;
   logic             skip_ff, skip_in;
   logic [CELLS-1:0] valid_ff, valid_in;

   // Second stage
   logic        b_valid_ff, b_valid_in;
   stage_b_type b_ff, a_word;

   logic             accept;
   logic             b_go;
   logic [COL_W-1:0] col_adv;
   logic [ROW_W-1:0] new_row;
   logic [COL_W-1:0] new_col;
   logic [7:0]       shadow_rd, shadow_q;
   logic             match;
   logic             wr_en;
   lcd_op_type       ops [2];
   logic [1:0]       n_ops;

   assign req_stall = b_valid_ff && !b_go;
   assign accept    = req_valid && !req_stall;

   // Classify the incoming word and work out the next cursor
   always_comb begin
      a_word          = '0;
      a_word.value    = req_word.value;
      a_word.last     = req_word.last;
      a_word.bl       = bl_ff;
      a_word.in_range = cur_col_ff < COL_W'(COLUMNS);
      a_word.idx      = CELL_W'(int'(cur_row_ff) * COLUMNS + int'(cur_col_ff));
      col_adv         = a_word.in_range ? COL_W'(cur_col_ff + 1'b1) : cur_col_ff;
      a_word.pos_now  = pos_byte(cur_row_ff, cur_col_ff);
      a_word.pos_next = pos_byte(cur_row_ff, col_adv);
      new_row = (req_word.row > 2'(ROWS - 1)) ? ROW_W'(ROWS - 1) : ROW_W'(req_word.row);
      new_col = (req_word.column > 6'(COLUMNS)) ? COL_W'(COLUMNS) : COL_W'(req_word.column);
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      bl_in      = bl_ff;
      case (req_word.mode)
         MODE_RAW_INSTR: begin
            a_word.simple    = 1'b1;
            a_word.simple_op = make_op(req_word.value, 1'b0, bl_ff, 1'b0);
         end
         MODE_RAW_DATA: begin
            a_word.simple    = 1'b1;
            a_word.simple_op = make_op(req_word.value, 1'b1, bl_ff, 1'b0);
         end
         MODE_PUT_CHAR: begin
            a_word.is_put    = 1'b1;
            a_word.simple    = a_word.in_range;
            a_word.simple_op = make_op(req_word.value, 1'b1, bl_ff, 1'b0);
            cur_col_in       = col_adv;
         end
         MODE_STR_CHAR: begin
            a_word.is_str = 1'b1;
            cur_col_in    = col_adv;
         end
         MODE_POSITION: begin
            a_word.simple    = 1'b1;
            a_word.clr_skip  = 1'b1;
            a_word.simple_op = make_op(pos_byte(new_row, new_col), 1'b0, bl_ff, 1'b0);
            cur_row_in       = new_row;
            cur_col_in       = new_col;
         end
         MODE_CLEAR: begin
            a_word.simple    = 1'b1;
            a_word.clr_skip  = 1'b1;
            a_word.do_clear  = 1'b1;
            a_word.simple_op = make_op(CMD_CLEAR, 1'b0, bl_ff, 1'b0);
            cur_row_in       = '0;
            cur_col_in       = '0;
         end
         MODE_HOME: begin
            a_word.simple    = 1'b1;
            a_word.clr_skip  = 1'b1;
            a_word.simple_op = make_op(CMD_HOME, 1'b0, bl_ff, 1'b0);
            cur_row_in       = '0;
            cur_col_in       = '0;
         end
         MODE_DISPLAY: begin
            a_word.simple    = 1'b1;
            a_word.simple_op = make_op(CMD_DISPLAY | {5'b0, req_word.display_on,
                                       req_word.show_cursor, req_word.show_blink},
                                       1'b0, bl_ff, 1'b0);
         end
         MODE_BACKLIGHT: begin
            if (req_word.backlight_request != bl_ff) begin
               a_word.simple    = 1'b1;
               a_word.simple_op = make_op(req_word.backlight_request ? PIN_BL : 8'h00,
                                          1'b0, bl_ff, 1'b1);
               bl_in            = req_word.backlight_request;
            end
         end
         default: begin
            a_word.simple = 1'b0;
         end
      endcase
   end

   // Shadow screen storage; entries not written since the last clear read as space
   chlcd_ram #(
      .WIDTH (8),
      .DEPTH (CELLS)
   ) u_shadow (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (b_ff.idx),
      .wr_data (b_ff.value),
      .rd_en   (accept),
      .rd_addr (a_word.idx),
      .rd_data (shadow_rd)
   );

   assign shadow_q = valid_ff[b_ff.idx] ? shadow_rd : SPACE_CHAR;
   assign match    = shadow_q == b_ff.value;

   // Build the operations of the word in the second stage
   always_comb begin
      ops[0]  = '0;
      ops[1]  = '0;
      n_ops   = 2'd0;
      skip_in = skip_ff;
      wr_en   = 1'b0;
      if (b_ff.simple) begin
         ops[0] = b_ff.simple_op;
         n_ops  = 2'd1;
      end
      if (b_ff.is_str) begin
         if (b_ff.in_range) begin
            if (match) begin
               skip_in = 1'b1;
            end else begin
               if (skip_in) begin
                  ops[0]  = make_op(b_ff.pos_now, 1'b0, b_ff.bl, 1'b0);
                  n_ops   = 2'd1;
                  skip_in = 1'b0;
               end
               ops[n_ops[0]] = make_op(b_ff.value, 1'b1, b_ff.bl, 1'b0);
               n_ops         = 2'(n_ops + 1'b1);
               wr_en         = b_valid_ff;
            end
         end
         if (b_ff.last && skip_in) begin
            ops[n_ops[0]] = make_op(b_ff.pos_next, 1'b0, b_ff.bl, 1'b0);
            n_ops         = 2'(n_ops + 1'b1);
            skip_in       = 1'b0;
         end
      end
      if (b_ff.is_put && b_ff.in_range) begin
         wr_en = b_valid_ff;
      end
      if (b_ff.clr_skip) begin
         skip_in = 1'b0;
      end
      // Mark the final operation of the word
      if (n_ops == 2'd2) begin
         ops[1].last = 1'b1;
      end else begin
         ops[0].last = 1'b1;
      end
      b_go  = b_valid_ff && (QCNT_W'(n_ops) <= q_free);
      wr_en = wr_en && b_go;
   end

   always_comb begin
      push.count = b_go ? n_ops : 2'd0;
      push.op0   = ops[0];
      push.op1   = ops[1];
   end

   // Shadow valid bits: drop all on clear, set on write
   always_comb begin
      valid_in = valid_ff;
      if (b_go && b_ff.do_clear) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[b_ff.idx] = 1'b1;
      end
   end

   assign b_valid_in = accept || (b_valid_ff && !b_go);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff <= '0;
         cur_col_ff <= '0;
         bl_ff      <= 1'b0;
         skip_ff    <= 1'b0;
         valid_ff   <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            cur_row_ff <= cur_row_in;
            cur_col_ff <= cur_col_in;
            bl_ff      <= bl_in;
         end
         if (b_go) begin
            skip_ff <= skip_in;
         end
         valid_ff   <= valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         b_ff <= a_word;
      end
   end

   `CHLCD_CHECK(a_push_fits, clock, reset, push.count != 2'd0, QCNT_W'(push.count) <= q_free, "front pushed more words than the queue holds")
   `CHLCD_CHECK_NEXT(a_clear_empties, clock, reset, b_go && b_ff.do_clear, valid_ff == '0, "shadow not cleared after clear")

endmodule

// ===== src/chlcd_queue.sv =====
// Short queue of LCD operations between front and back.
`include "char_lcd_shadow_write_engine_assert.svh"

module chlcd_queue
   import chlcd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  push_type          push,
   output logic [QCNT_W-1:0] q_free,
   output head_type          head,
   input  logic              pop
);

   lcd_op_type        entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic [QPTR_W-1:0] wr_ptr_nx;

   assign wr_ptr_nx  = QPTR_W'(wr_ptr_ff + 1'b1);
   assign q_free     = QCNT_W'(QDEPTH) - cnt_ff;
   assign head.valid = cnt_ff != '0;
   assign head.op    = entry_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = QPTR_W'(wr_ptr_ff + push.count);
      rd_ptr_in = pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = QCNT_W'(cnt_ff + push.count - QCNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store up to two words per cycle
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.op0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_nx] <= push.op1;
      end
   end

   `CHLCD_CHECK(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= QCNT_W'(QDEPTH), "queue count past depth")
   `CHLCD_CHECK(a_pop_nonempty, clock, reset, pop, cnt_ff != '0, "pop from empty queue")

endmodule

// ===== src/chlcd_back.sv =====
// Back end: splits LCD operations into expander bytes behind an output register.
`include "char_lcd_shadow_write_engine_assert.svh"

module chlcd_back
   import chlcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  head_type     head,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   logic [2:0]   step_ff, step_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         out_free;
   logic         fire;
   logic         en;
   logic [3:0]   nib;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire     = head.valid && out_free;
   assign pop      = fire && (head.op.single || step_ff == STEP_LAST);

   // Form the expander byte for this step: high nibble first, enable pulsed mid-triplet; a single op is sent as is
   always_comb begin
      en  = (step_ff == 3'd1) || (step_ff == 3'd4);
      nib = (step_ff < 3'd3) ? head.op.data[7:4] : head.op.data[3:0];
      if (head.op.single) begin
         rsp_word_in.expander_byte = head.op.data;
      end else begin
         rsp_word_in.expander_byte = {nib, head.op.bl, en, 1'b0, head.op.rs};
      end
      rsp_word_in.last_byte = head.op.last && pop;
      step_in = pop ? 3'd0 : (fire ? 3'(step_ff + 1'b1) : step_ff);
      rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the word until taken
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `CHLCD_CHECK(a_step_mid_op, clock, reset, step_ff != 3'd0, head.valid && !head.op.single, "nibble step without an LCD byte at the head")

endmodule

// ===== src/char_lcd_shadow_write_engine.sv =====
// An accepted word waits in the front's second stage; its operations go through the queue
// to the back's output register, six expander bytes per LCD byte, one per cycle while
// rsp_stall is low; an item gives 0, 1, 6 or 12. The nibble sequencer sets the sustained
// rate; the front takes words back to back while the four-entry queue has room.
// Reset is synchronous: shadow reads as spaces, cursor home, backlight off, queue empty.
module char_lcd_shadow_write_engine
   import chlcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   push_type          push;
   logic [QCNT_W-1:0] q_free;
   head_type          head;
   logic              pop;

   chlcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .q_free    (q_free),
      .push      (push)
   );

   chlcd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .q_free (q_free),
      .head   (head),
      .pop    (pop)
   );

   chlcd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
